// ===== hdl/bgc_pkg.sv =====
// Shared types and constants for the binocular gaze controller.
package bgc_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_P_ONE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_P_TWO    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIGMA    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VEE      = 3'd5;

  // Reset value of P1: 1.0 in Q4.12
  localparam int unsigned GAIN_P_ONE_RESET = 4096;

  // Fraction bits dropped when rounding a product sum
  localparam int unsigned FRAC_SHIFT = 12;

  // Multiplier gain-side operand select
  typedef enum logic [2:0] {
    A_P1,
    A_P2,
    A_GA,
    A_GB,
    A_GC,
    A_GD
  } a_sel_e;

  // Multiplier data-side operand select
  typedef enum logic [2:0] {
    B_K,
    B_SG,
    B_N,
    B_V,
    B_IL,
    B_EL,
    B_IR,
    B_ER
  } b_sel_e;

  // Command word from the sequencer to the datapath
  typedef struct packed {
    logic       capture;   // latch the input item
    logic       integrate; // update the four integrators
    logic       mul;       // issue one multiply
    a_sel_e     a_sel;
    b_sel_e     b_sel;
    logic       axis_y;    // vertical axis operands
    logic       sub;       // subtract the product
    logic       first;     // first term of a sum
    logic       last;      // last term of a sum
    logic       to_out;    // sum goes to a result, else to a combined gain
    logic [1:0] dest;      // combined gain or result index
    logic       load_out;  // move results to the output register
  } cmd_t;

endpackage

// ===== hdl/bgc_ctrl.sv =====
// Sequencer for the gaze controller: steps the shared multiplier through one tick.
module bgc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bgc_pkg::cmd_t cmd_o
);
  import bgc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_GAIN  = 3'd1;
  localparam logic [2:0] S_INTEG = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_OUTP  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam logic [3:0] GAIN_LAST  = 4'd7;
  localparam logic [3:0] OUT_LAST   = 4'd15;
  localparam logic [3:0] DRAIN_LAST = 4'd1;

  logic [2:0] state_q, state_d;
  logic [3:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;
  logic [1:0] out_idx;
  logic [1:0] term;
  logic [1:0] gain_idx;
  logic       in_acc;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_idx     = step_q[3:2];
  assign term        = step_q[1:0];
  // right-eye commands use the combined gains in swapped pairs
  assign gain_idx    = term ^ {out_idx[0], 1'b0};

  // Decode state and step into a command
  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.capture = in_acc;
      end
      S_GAIN: begin
        cmd_o.mul   = 1'b1;
        cmd_o.first = ~step_q[0];
        cmd_o.last  = step_q[0];
        cmd_o.dest  = step_q[2:1];
        cmd_o.a_sel = (step_q[2] ^ step_q[0]) ? A_P1 : A_P2;
        cmd_o.b_sel = step_q[1] ? (step_q[0] ? B_V : B_N) : (step_q[0] ? B_SG : B_K);
      end
      S_INTEG: begin
        cmd_o.integrate = 1'b1;
      end
      S_OUTP: begin
        cmd_o.mul    = 1'b1;
        cmd_o.to_out = 1'b1;
        cmd_o.axis_y = out_idx[1];
        cmd_o.first  = (term == 2'd0);
        cmd_o.last   = (term == 2'd3);
        cmd_o.dest   = out_idx;
        // right vertical command is negated: flip every term's sign
        cmd_o.sub    = ((term == 2'd1) || (term == 2'd2)) ^ (out_idx == 2'd3);
        case (term)
          2'd0:    cmd_o.b_sel = B_IL;
          2'd1:    cmd_o.b_sel = B_EL;
          2'd2:    cmd_o.b_sel = B_IR;
          default: cmd_o.b_sel = B_ER;
        endcase
        case (gain_idx)
          2'd0:    cmd_o.a_sel = A_GA;
          2'd1:    cmd_o.a_sel = A_GB;
          2'd2:    cmd_o.a_sel = A_GC;
          default: cmd_o.a_sel = A_GD;
        endcase
      end
      S_DONE: begin
        cmd_o.load_out = ~out_valid_q | out_ready_i;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_GAIN;
          step_d  = '0;
        end
      end
      S_GAIN: begin
        step_d = step_q + 4'd1;
        if (step_q == GAIN_LAST) begin
          state_d = S_INTEG;
          step_d  = '0;
        end
      end
      S_INTEG: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        state_d = S_OUTP;
        step_d  = '0;
      end
      S_OUTP: begin
        step_d = step_q + 4'd1;
        if (step_q == OUT_LAST) begin
          state_d = S_DRAIN;
          step_d  = '0;
        end
      end
      S_DRAIN: begin
        step_d = step_q + 4'd1;
        if (step_q == DRAIN_LAST) begin
          state_d = S_DONE;
          step_d  = '0;
        end
      end
      S_DONE: begin
        if (~out_valid_q | out_ready_i) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
        step_d  = '0;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hdl/bgc_datapath.sv =====
// Datapath for the gaze controller: gains, integrators, shared multiplier and accumulator.
module bgc_datapath #(
  parameter int AW = 16,
  parameter int GW = 16,
  parameter int IW = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bgc_pkg::cmd_t                   cmd_i,
  input  logic                            cfg_we_i,
  input  logic [bgc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [GW-1:0]                   cfg_data_i,
  input  logic signed [AW-1:0]            left_rel_x_i,
  input  logic signed [AW-1:0]            right_rel_x_i,
  input  logic signed [AW-1:0]            left_rel_y_i,
  input  logic signed [AW-1:0]            right_rel_y_i,
  output logic signed [AW-1:0]            left_cmd_x_o,
  output logic signed [AW-1:0]            right_cmd_x_o,
  output logic signed [AW-1:0]            left_cmd_y_o,
  output logic signed [AW-1:0]            right_cmd_y_o
);
  import bgc_pkg::*;

  // Operand width for integrals and errors
  localparam int OW   = (IW > AW) ? IW : AW;
  // Sum of two gain products, wrapping at 64 bits
  localparam int GSW  = (2 * GW + 1 > 64) ? 64 : 2 * GW + 1;
  // Combined gain width
  localparam int CGW  = GSW - FRAC_SHIFT;
  localparam int MA   = (CGW > GW) ? CGW : GW;
  localparam int MB   = (OW > GW) ? OW : GW;
  localparam int PFW  = MA + MB;
  localparam int OSW  = CGW + OW + 2;
  localparam int AXW  = (OSW > GSW) ? OSW : GSW;
  localparam int ACCW = (AXW > 64) ? 64 : AXW;
  localparam int RW   = ACCW - FRAC_SHIFT;
  localparam int ISW  = OW + 1;
  localparam int SW   = ((RW > AW) ? RW : AW) + 1;

  // Configured gains
  logic signed [GW-1:0] p1_q, p2_q, k_q, sg_q, n_q, v_q;
  // Captured errors and integrators
  logic signed [AW-1:0] elx_q, erx_q, ely_q, ery_q;
  logic signed [IW-1:0] ilx_q, irx_q, ily_q, iry_q;
  // Combined gains and results
  logic signed [CGW-1:0] cg_q [4];
  logic signed [AW-1:0]  res_q [4];
  logic signed [AW-1:0]  out_q [4];

  logic signed [MA-1:0]  a_op;
  logic signed [MB-1:0]  b_op;
  logic signed [PFW-1:0] prod_full;
  logic [ACCW-1:0]       prod_ext;
  logic [ACCW-1:0]       prod_q;
  logic [ACCW-1:0]       acc_q, acc_d, acc_base;
  logic [RW-1:0]         rnd;
  logic signed [AW-1:0]  sat_out;

  logic       acc_vld_q, wb_vld_q;
  logic       acc_sub_q, acc_first_q, acc_last_q, acc_out_q;
  logic [1:0] acc_dest_q;
  logic       wb_out_q;
  logic [1:0] wb_dest_q;

  function automatic logic signed [IW-1:0] sat_int(input logic signed [ISW-1:0] s);
    logic signed [ISW-1:0] hi;
    logic signed [ISW-1:0] lo;
    hi = '0;
    hi[IW-2:0] = '1;
    lo = ~hi;
    if (s > hi) return hi[IW-1:0];
    if (s < lo) return lo[IW-1:0];
    return s[IW-1:0];
  endfunction

  function automatic logic signed [AW-1:0] sat_ang(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    hi = '0;
    hi[AW-2:0] = '1;
    lo = ~hi;
    if (s > hi) return hi[AW-1:0];
    if (s < lo) return lo[AW-1:0];
    return s[AW-1:0];
  endfunction

  // Write configuration registers; unknown indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q <= GW'(GAIN_P_ONE_RESET);
      p2_q <= '0;
      k_q  <= '0;
      sg_q <= '0;
      n_q  <= '0;
      v_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_P_ONE:    p1_q <= cfg_data_i;
        REG_P_TWO:    p2_q <= cfg_data_i;
        REG_INTEGRAL: k_q  <= cfg_data_i;
        REG_SIGMA:    sg_q <= cfg_data_i;
        REG_DIRECT:   n_q  <= cfg_data_i;
        REG_VEE:      v_q  <= cfg_data_i;
        default:      p1_q <= p1_q;
      endcase
    end
  end

  // Capture the input item
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      elx_q <= left_rel_x_i;
      erx_q <= right_rel_x_i;
      ely_q <= left_rel_y_i;
      ery_q <= right_rel_y_i;
    end
  end

  // Advance the saturating integrators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ilx_q <= '0;
      irx_q <= '0;
      ily_q <= '0;
      iry_q <= '0;
    end else if (cmd_i.integrate) begin
      ilx_q <= sat_int(ISW'(ilx_q) + ISW'(elx_q));
      irx_q <= sat_int(ISW'(irx_q) + ISW'(erx_q));
      ily_q <= sat_int(ISW'(ily_q) + ISW'(ely_q));
      iry_q <= sat_int(ISW'(iry_q) + ISW'(ery_q));
    end
  end

  // Select multiplier operands
  always_comb begin
    case (cmd_i.a_sel)
      A_P1:    a_op = MA'(p1_q);
      A_P2:    a_op = MA'(p2_q);
      A_GA:    a_op = MA'(cg_q[0]);
      A_GB:    a_op = MA'(cg_q[1]);
      A_GC:    a_op = MA'(cg_q[2]);
      A_GD:    a_op = MA'(cg_q[3]);
      default: a_op = '0;
    endcase
    case (cmd_i.b_sel)
      B_K:     b_op = MB'(k_q);
      B_SG:    b_op = MB'(sg_q);
      B_N:     b_op = MB'(n_q);
      B_V:     b_op = MB'(v_q);
      B_IL:    b_op = cmd_i.axis_y ? MB'(ily_q) : MB'(ilx_q);
      B_EL:    b_op = cmd_i.axis_y ? MB'(ely_q) : MB'(elx_q);
      B_IR:    b_op = cmd_i.axis_y ? MB'(iry_q) : MB'(irx_q);
      default: b_op = cmd_i.axis_y ? MB'(ery_q) : MB'(erx_q);
    endcase
  end

  assign prod_full = a_op * b_op;

  // Fit the product to the accumulator, wrapping like the accumulator does
  generate
    if (PFW >= ACCW) begin : g_prod_trunc
      assign prod_ext = prod_full[ACCW-1:0];
    end else begin : g_prod_ext
      assign prod_ext = ACCW'(prod_full);
    end
  endgenerate

  // Accumulate and round
  assign acc_base = acc_first_q ? '0 : acc_q;
  assign acc_d    = acc_sub_q ? (acc_base - prod_q) : (acc_base + prod_q);
  // round half up: floor of the shifted sum plus the dropped half bit
  assign rnd      = acc_q[ACCW-1:FRAC_SHIFT] + {{(RW-1){1'b0}}, acc_q[FRAC_SHIFT-1]};
  assign sat_out  = sat_ang(SW'(signed'(rnd)));

  // Pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_q <= 1'b0;
      wb_vld_q  <= 1'b0;
    end else begin
      acc_vld_q <= cmd_i.mul;
      wb_vld_q  <= acc_vld_q & acc_last_q;
    end
  end

  // Multiply, accumulate and write back stages
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q      <= prod_ext;
      acc_sub_q   <= cmd_i.sub;
      acc_first_q <= cmd_i.first;
      acc_last_q  <= cmd_i.last;
      acc_out_q   <= cmd_i.to_out;
      acc_dest_q  <= cmd_i.dest;
    end
    if (acc_vld_q) begin
      acc_q     <= acc_d;
      wb_out_q  <= acc_out_q;
      wb_dest_q <= acc_dest_q;
    end
    if (wb_vld_q) begin
      if (wb_out_q) begin
        res_q[wb_dest_q] <= sat_out;
      end else begin
        cg_q[wb_dest_q] <= rnd[CGW-1:0];
      end
    end
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q[0] <= res_q[0];
      out_q[1] <= res_q[1];
      out_q[2] <= res_q[2];
      out_q[3] <= res_q[3];
    end
  end

  assign left_cmd_x_o  = out_q[0];
  assign right_cmd_x_o = out_q[1];
  assign left_cmd_y_o  = out_q[2];
  assign right_cmd_y_o = out_q[3];

endmodule

// ===== hdl/binocular_gaze_controller.sv =====
// One item at a time: the next is taken once the last is loaded into the output register.
// The work is set by the single shared multiplier: 8 products form the combined gains,
// 16 products form the four drive commands, plus integrate, fill and drain cycles.
// A finished result waits in the output register while the next item is taken.
// Reset: integrators clear to zero, gains return to P1 = 1.0 and the rest zero,
// no item is in flight and the output is not valid.
module binocular_gaze_controller #(
  parameter int ANGLE_WIDTH      = 16,
  parameter int GAIN_WIDTH       = 16,
  parameter int INTEGRATOR_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bgc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [GAIN_WIDTH-1:0]         cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [ANGLE_WIDTH-1:0] left_rel_x_i,
  input  logic signed [ANGLE_WIDTH-1:0] right_rel_x_i,
  input  logic signed [ANGLE_WIDTH-1:0] left_rel_y_i,
  input  logic signed [ANGLE_WIDTH-1:0] right_rel_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [ANGLE_WIDTH-1:0] left_cmd_x_o,
  output logic signed [ANGLE_WIDTH-1:0] right_cmd_x_o,
  output logic signed [ANGLE_WIDTH-1:0] left_cmd_y_o,
  output logic signed [ANGLE_WIDTH-1:0] right_cmd_y_o
);
  import bgc_pkg::*;

  cmd_t cmd;

  // Sequence one tick
  bgc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Compute gains, integrals and commands
  bgc_datapath #(
    .AW (ANGLE_WIDTH),
    .GW (GAIN_WIDTH),
    .IW (INTEGRATOR_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .left_rel_x_i  (left_rel_x_i),
    .right_rel_x_i (right_rel_x_i),
    .left_rel_y_i  (left_rel_y_i),
    .right_rel_y_i (right_rel_y_i),
    .left_cmd_x_o  (left_cmd_x_o),
    .right_cmd_x_o (right_cmd_x_o),
    .left_cmd_y_o  (left_cmd_y_o),
    .right_cmd_y_o (right_cmd_y_o)
  );

endmodule
